[rtl/ogg_opus_packet_demux_top_defines.svh]
// Assertion macros for the Ogg/Opus packet demux.
`ifndef OGG_OPUS_PACKET_DEMUX_TOP_DEFINES_SVH
`define OGG_OPUS_PACKET_DEMUX_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, idle in reset.
`define OPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ogg_opus_packet_demux: assertion failed");

// Next-cycle implication, sampled on clk, idle in reset.
`define OPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ogg_opus_packet_demux: assertion failed");

`else

`define OPD_ASSERT_IMPL(label, ante, cons)
`define OPD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/opd_pkg.sv]
`default_nettype none

package opd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Page header layout
    localparam logic [4:0] HDR_SYNC_LEN = 5'd4;
    localparam logic [4:0] HDR_COUNT_POS = 5'd26;
    localparam logic [7:0] LACE_RUN     = 8'd255;
    // Minimum packet lengths, as last offsets (length - 1)
    localparam logic [15:0] HEAD_MIN_LAST = 16'd18;
    localparam logic [15:0] TAGS_MIN_LAST = 16'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  packet_byte;
        logic        packet_first;
        logic        packet_last;
        logic [7:0]  channel_count;
        logic [31:0] stream_rate;
        logic        stream_end;
        logic        truncated;
    } result_t;

    // Capture pattern "OggS"
    function automatic logic [7:0] sync_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h4F;
            2'd1:    c = 8'h67;
            2'd2:    c = 8'h67;
            default: c = 8'h53;
        endcase
        return c;
    endfunction

    // "OpusHead"
    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h4F;
            3'd1:    c = 8'h70;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h48;
            3'd5:    c = 8'h65;
            3'd6:    c = 8'h61;
            default: c = 8'h64;
        endcase
        return c;
    endfunction

    // "OpusTags"
    function automatic logic [7:0] tags_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h4F;
            3'd1:    c = 8'h70;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h54;
            3'd5:    c = 8'h61;
            3'd6:    c = 8'h67;
            default: c = 8'h73;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/ogg_opus_packet_demux_top.sv]
`default_nettype none
`include "ogg_opus_packet_demux_top_defines.svh"

// Ogg page demux for an Opus stream, one stream byte per item. It accepts a
// new item every cycle unless a held result is stalled; each item gives zero
// or one result in the cycle after acceptance, held in an output register;
// input stalls while result_stall holds it. The lacing table is compacted
// into a one-write, one-read memory while read (empty packets dropped, a zero
// after a 255 run marks the run's end); the body walks the segments byte by
// byte with a one-entry read-ahead. No clearing pass is needed after reset.
// OpusHead yields one header result; audio starts after OpusTags.
module ogg_opus_packet_demux_top #(
    parameter int MAX_SEGMENTS = 255
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire opd_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output opd_pkg::result_t     result
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [7:0] SEG_LIMIT = 8'(MAX_SEGMENTS);

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_HEADER,
        PH_TABLE,
        PH_BODY
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [1:0]      sync_reg, sync_next;
    logic [4:0]      hdr_pos_reg, hdr_pos_next;
    logic [7:0]      total_reg, total_next;
    logic [7:0]      raw_pos_reg, raw_pos_next;
    logic [7:0]      remain_reg, remain_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            open_reg, open_next;
    logic [IW-1:0]   ptr_reg, ptr_next;
    logic            fresh_reg, fresh_next;
    logic [7:0]      seg_left_reg, seg_left_next;
    logic [15:0]     off_reg, off_next;
    logic            magic_reg, magic_next;
    logic            head_reg, head_next;
    logic            tags_reg, tags_next;
    logic [7:0]      chan_reg, chan_next;
    logic [31:0]     rate_reg, rate_next;

    logic [8:0]      lace_mem [MAX_SEGMENTS];
    logic [8:0]      rdata_reg;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [8:0]      mem_wdata;

    logic             result_valid_reg;
    opd_pkg::result_t result_reg;
    opd_pkg::result_t res;
    logic             has_res;
    logic             accept;

    // body helpers
    logic [7:0]  b;
    logic [7:0]  seg_val;
    logic        seg_endb;
    logic [7:0]  left;
    logic        seg_done;
    logic        last_seg;
    logic        pkt_end;
    logic        magic_now;
    logic [7:0]  chan_now;
    logic [31:0] rate_now;

    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign b        = item.data_byte;
    assign seg_val  = rdata_reg[7:0];
    assign seg_endb = rdata_reg[8];
    assign left     = fresh_reg ? seg_val : seg_left_reg;
    assign seg_done = (left == 8'd1);
    assign last_seg = (CW'(ptr_reg) == count_reg - CW'(1));
    assign pkt_end  = seg_done && (seg_val != opd_pkg::LACE_RUN || seg_endb || last_seg);

    // Per-byte parse step
    always_comb
    begin
        phase_next    = phase_reg;
        sync_next     = sync_reg;
        hdr_pos_next  = hdr_pos_reg;
        total_next    = total_reg;
        raw_pos_next  = raw_pos_reg;
        remain_next   = remain_reg;
        count_next    = count_reg;
        open_next     = open_reg;
        ptr_next      = ptr_reg;
        fresh_next    = fresh_reg;
        seg_left_next = seg_left_reg;
        off_next      = off_reg;
        magic_next    = magic_reg;
        head_next     = head_reg;
        tags_next     = tags_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[IW-1:0];
        mem_wdata     = {1'b0, b};
        res           = '0;
        has_res       = 1'b0;
        magic_now     = magic_reg;
        chan_now      = chan_reg;
        rate_now      = rate_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (b == opd_pkg::sync_char(sync_reg))
                    begin
                        sync_next = sync_reg + 2'd1;
                        if (sync_reg == 2'd3)
                        begin
                            sync_next    = 2'd0;
                            hdr_pos_next = opd_pkg::HDR_SYNC_LEN;
                            phase_next   = PH_HEADER;
                        end
                    end
                    else
                    begin
                        sync_next = (b == opd_pkg::sync_char(2'd0)) ? 2'd1 : 2'd0;
                    end
                end
                PH_HEADER:
                begin
                    if (hdr_pos_reg == opd_pkg::HDR_COUNT_POS)
                    begin
                        remain_next  = b;
                        total_next   = (b > SEG_LIMIT) ? SEG_LIMIT : b;
                        raw_pos_next = 8'd0;
                        count_next   = '0;
                        open_next    = 1'b0;
                        ptr_next     = '0;
                        hdr_pos_next = 5'd0;
                        phase_next   = (b == 8'd0) ? PH_SEARCH : PH_TABLE;
                    end
                    else
                    begin
                        hdr_pos_next = hdr_pos_reg + 5'd1;
                    end
                end
                PH_TABLE:
                begin
                    // compact lacing values into the segment store
                    if (raw_pos_reg < total_reg)
                    begin
                        raw_pos_next = raw_pos_reg + 8'd1;
                        if (b == 8'd0)
                        begin
                            if (open_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = IW'(count_reg - CW'(1));
                                mem_wdata = {1'b1, opd_pkg::LACE_RUN};
                                open_next = 1'b0;
                            end
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            open_next  = (b == opd_pkg::LACE_RUN);
                        end
                    end
                    remain_next = remain_reg - 8'd1;
                    if (remain_reg == 8'd1)
                    begin
                        ptr_next   = '0;
                        fresh_next = 1'b1;
                        off_next   = 16'd0;
                        magic_next = 1'b1;
                        phase_next = (count_next == '0) ? PH_SEARCH : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (!head_reg)
                    begin
                        if (off_reg < 16'd8 && b != opd_pkg::head_char(off_reg[2:0]))
                            magic_now = 1'b0;
                        if (off_reg == 16'd9)
                            chan_now = b;
                        if (off_reg == 16'd12)
                            rate_now[7:0] = b;
                        if (off_reg == 16'd13)
                            rate_now[15:8] = b;
                        if (off_reg == 16'd14)
                            rate_now[23:16] = b;
                        if (off_reg == 16'd15)
                            rate_now[31:24] = b;
                    end
                    else if (!tags_reg)
                    begin
                        if (off_reg < 16'd8 && b != opd_pkg::tags_char(off_reg[2:0]))
                            magic_now = 1'b0;
                    end
                    else
                    begin
                        res.result_kind  = opd_pkg::KIND_AUDIO;
                        res.packet_byte  = b;
                        res.packet_first = (off_reg == 16'd0);
                        res.packet_last  = pkt_end;
                        has_res          = 1'b1;
                    end
                    chan_next  = chan_now;
                    rate_next  = rate_now;
                    magic_next = magic_now;
                    off_next   = off_reg + 16'd1;

                    // packet close: header checks, then reset per-packet state
                    if (pkt_end)
                    begin
                        if (!head_reg)
                        begin
                            if (magic_now && off_reg >= opd_pkg::HEAD_MIN_LAST)
                            begin
                                head_next         = 1'b1;
                                res.result_kind   = opd_pkg::KIND_HEADER;
                                res.channel_count = chan_now;
                                res.stream_rate   = rate_now;
                                has_res           = 1'b1;
                            end
                        end
                        else if (!tags_reg)
                        begin
                            if (magic_now && off_reg >= opd_pkg::TAGS_MIN_LAST)
                                tags_next = 1'b1;
                        end
                        off_next   = 16'd0;
                        magic_next = 1'b1;
                    end

                    // segment walk
                    if (seg_done)
                    begin
                        fresh_next = 1'b1;
                        if (last_seg)
                        begin
                            phase_next = PH_SEARCH;
                            sync_next  = 2'd0;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        seg_left_next = left - 8'd1;
                        fresh_next    = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                end
            endcase

            // end of stream closes out and restarts
            if (item.end_of_stream)
            begin
                if (!has_res)
                    res.result_kind = opd_pkg::KIND_END;
                has_res       = 1'b1;
                res.stream_end = 1'b1;
                res.truncated  = (phase_next != PH_SEARCH);
                phase_next    = PH_SEARCH;
                sync_next     = 2'd0;
                hdr_pos_next  = 5'd0;
                total_next    = 8'd0;
                raw_pos_next  = 8'd0;
                remain_next   = 8'd0;
                count_next    = '0;
                open_next     = 1'b0;
                ptr_next      = '0;
                fresh_next    = 1'b1;
                seg_left_next = 8'd0;
                off_next      = 16'd0;
                magic_next    = 1'b1;
                head_next     = 1'b0;
                tags_next     = 1'b0;
                chan_next     = 8'd0;
                rate_next     = 32'd0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SEARCH;
            sync_reg         <= 2'd0;
            hdr_pos_reg      <= 5'd0;
            total_reg        <= 8'd0;
            raw_pos_reg      <= 8'd0;
            remain_reg       <= 8'd0;
            count_reg        <= '0;
            open_reg         <= 1'b0;
            ptr_reg          <= '0;
            fresh_reg        <= 1'b1;
            seg_left_reg     <= 8'd0;
            off_reg          <= 16'd0;
            magic_reg        <= 1'b1;
            head_reg         <= 1'b0;
            tags_reg         <= 1'b0;
            chan_reg         <= 8'd0;
            rate_reg         <= 32'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            sync_reg     <= sync_next;
            hdr_pos_reg  <= hdr_pos_next;
            total_reg    <= total_next;
            raw_pos_reg  <= raw_pos_next;
            remain_reg   <= remain_next;
            count_reg    <= count_next;
            open_reg     <= open_next;
            ptr_reg      <= ptr_next;
            fresh_reg    <= fresh_next;
            seg_left_reg <= seg_left_next;
            off_reg      <= off_next;
            magic_reg    <= magic_next;
            head_reg     <= head_next;
            tags_reg     <= tags_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            if (accept)
                result_valid_reg <= has_res;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept && has_res)
            result_reg <= res;
    end

    // Segment store: one write, one registered read-ahead with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
            lace_mem[mem_waddr] <= mem_wdata;
        if (mem_we && mem_waddr == ptr_next)
            rdata_reg <= mem_wdata;
        else
            rdata_reg <= lace_mem[ptr_next];
    end

    `OPD_ASSERT_IMPL(a_trunc_ends, result_valid && result.truncated, result.stream_end)
    `OPD_ASSERT_IMPL(a_marks_audio, result_valid && result.result_kind != opd_pkg::KIND_AUDIO,
        !result.packet_first && !result.packet_last)
    `OPD_ASSERT_IMPL(a_body_has_segs, phase_reg == PH_BODY, count_reg != '0)
    `OPD_ASSERT_NEXT(a_eos_restart, accept && item.end_of_stream, phase_reg == PH_SEARCH)

endmodule

`default_nettype wire
